@@ rtl/core/ssp_pkg.sv @@
// Shared types and constants of the stream slot priority allocator.
package ssp_pkg;

  // Width of the slot and level scan counters; holds values up to 31.
  localparam int CNT_W   = 5;
  localparam int ID_W    = 32;
  localparam int TALLY_W = 12;
  localparam int CTR_W   = 8;

  typedef enum logic [3:0] {
    CMD_ALLOC       = 4'd0,
    CMD_SET_PRI     = 4'd1,
    CMD_REMOVE      = 4'd2,
    CMD_FREE        = 4'd3,
    CMD_STATUS      = 4'd4,
    CMD_CLEAR       = 4'd5,
    CMD_COUNT_BELOW = 4'd6,
    CMD_FIND        = 4'd7,
    CMD_COUNT_RUN   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    UOP_CMP,
    UOP_ADD,
    UOP_INC,
    UOP_DEC
  } uop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_SLOTS,
    S_ALLOC_LEVELS,
    S_ALLOC_FINISH,
    S_LEAVE,
    S_JOIN,
    S_FREE,
    S_STATUS,
    S_CLEAR,
    S_COUNT_BELOW,
    S_FIND,
    S_COUNT_RUN,
    S_REPLY
  } state_t;

  typedef struct packed {
    uop_t            op;
    logic [ID_W-1:0] a;
    logic [ID_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic [TALLY_W-1:0] res;
    logic               flag;
  } unit_rsp_t;

endpackage

@@ rtl/core/ssp_unit.sv @@
// Shared compare, add and saturating counter unit of the allocator.
module ssp_unit
  import ssp_pkg::*;
(
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  always_comb begin
    rsp = '0;
    case (req.op)
      UOP_CMP: begin
        rsp.flag = (req.a == req.b);
      end
      UOP_ADD: begin
        rsp.res = req.a[TALLY_W-1:0] + req.b[TALLY_W-1:0];
      end
      UOP_INC: begin
        // The flag marks a counter that was zero, so the new value is one.
        rsp.flag = (req.a[CTR_W-1:0] == '0);
        rsp.res  = {4'd0, (req.a[CTR_W-1:0] == 8'hFF) ? 8'hFF
                                                      : req.a[CTR_W-1:0] + 8'd1};
      end
      UOP_DEC: begin
        // The flag marks a counter that was already zero and stays there.
        rsp.flag = (req.a[CTR_W-1:0] == '0);
        rsp.res  = {4'd0, (req.a[CTR_W-1:0] == '0) ? 8'd0
                                                   : req.a[CTR_W-1:0] - 8'd1};
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/stream_slot_priority_allocator.sv @@
// Top level of the stream slot priority allocator: slot table, level lists and sequencer.
//
//   channel   ports                          handshake
//   -------   ----------------------------   -------------------------------------
//   command   in_command .. in_scanned_flag  beat taken at an edge with start && !busy
//   result    out_found .. out_wake          beat shown for one cycle with out_valid
//
// Every command beat gives exactly one result beat. busy rises at the edge that takes
// the command and falls after the cycle in which out_valid is high, so the next
// command can be taken in the cycle that follows the result.
// Allocate walks the slots one per cycle and then, if needed, the lower priority
// levels one per cycle. Set priority and remove pass through a leave step and a
// join step, count below walks the levels under the given one, find id and count
// running walk the slots, free, status and clear update the table directly, and the
// unused codes go straight to the result.
// The single shared compare/add unit sets this pace: each slot scan and count step
// uses it once, and the level scan reads one level list per cycle.
// Reset is synchronous; it clears the table, the level lists and counters (level 0
// starts holding NUM_SLOTS) and the active stream count. The receiver cannot stall.
module stream_slot_priority_allocator
  import ssp_pkg::*;
#(
  parameter int NUM_SLOTS  = 4,
  parameter int NUM_LEVELS = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [1:0]  in_slot,
  input  logic [3:0]  in_level,
  input  logic [31:0] in_stream_id,
  input  logic        in_locked_flag,
  input  logic        in_running_flag,
  input  logic        in_scanned_flag,
  output logic        out_valid,
  output logic        out_found,
  output logic [1:0]  out_chosen_slot,
  output logic [11:0] out_tally,
  output logic        out_underflow,
  output logic        out_wake
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LVL_W  = $clog2(NUM_LEVELS);

  // Sequencer state.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   lcnt_r, lcnt_nxt;
  logic               sel_found_r, sel_found_nxt;
  logic               free_found_r, free_found_nxt;

  // Slot table, level lists and counters.
  logic [ID_W-1:0]      ident_r [NUM_SLOTS];
  logic [ID_W-1:0]      ident_nxt [NUM_SLOTS];
  logic [LVL_W-1:0]     slevel_r [NUM_SLOTS];
  logic [LVL_W-1:0]     slevel_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] scanned_r, scanned_nxt;
  logic [NUM_SLOTS-1:0] locked_r, locked_nxt;
  logic [NUM_SLOTS-1:0] running_r, running_nxt;
  logic [NUM_SLOTS-1:0] members_r [NUM_LEVELS];
  logic [NUM_SLOTS-1:0] members_nxt [NUM_LEVELS];
  logic [CTR_W-1:0]     counts_r [NUM_LEVELS];
  logic [CTR_W-1:0]     counts_nxt [NUM_LEVELS];
  logic [CTR_W-1:0]     active_r, active_nxt;

  // Latched command beat and working payload.
  logic [1:0]         cslot_r, cslot_nxt;
  logic [3:0]         lvl_r, lvl_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic               lock_in_r, lock_in_nxt;
  logic               run_in_r, run_in_nxt;
  logic               scan_in_r, scan_in_nxt;
  logic               join_member_r, join_member_nxt;
  logic [SLOT_W-1:0]  sel_r, sel_nxt;
  logic [SLOT_W-1:0]  free_idx_r, free_idx_nxt;

  // Result registers.
  logic               found_r, found_nxt;
  logic [1:0]         chosen_r, chosen_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               under_r, under_nxt;
  logic               wake_r, wake_nxt;

  // Shared unit.
  unit_req_t ureq;
  unit_rsp_t ursp;

  logic               accept;
  logic               slot_ok;
  logic [SLOT_W-1:0]  sidx;
  logic [SLOT_W-1:0]  tgt;
  logic [LVL_W-1:0]   lidx;
  logic [LVL_W-1:0]   lvl_clamped;
  logic [LVL_W-1:0]   p_old;
  logic [LVL_W-1:0]   np;
  logic [CNT_W-1:0]   lnext;
  logic               last_slot;
  logic               last_level;
  logic               mark_ok;
  logic [NUM_SLOTS-1:0] mem_vec;
  logic [NUM_SLOTS-1:0] unl_vec;

  // Lowest set bit of a slot mask.
  function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  // Highest set bit of a slot mask: the last member seen in a walk upward.
  function automatic logic [SLOT_W-1:0] last_set(input logic [NUM_SLOTS-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (v[i]) begin
        r = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  ssp_unit u_unit (
    .req (ureq),
    .rsp (ursp)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign slot_ok     = ({3'd0, in_slot} < CNT_W'(NUM_SLOTS));
  assign sidx        = idx_r[SLOT_W-1:0];
  assign tgt         = SLOT_W'(cslot_r);
  assign lidx        = lcnt_r[LVL_W-1:0];
  assign lvl_clamped = ({1'b0, lvl_r} >= CNT_W'(NUM_LEVELS)) ? LVL_W'(NUM_LEVELS - 1)
                                                             : LVL_W'(lvl_r);
  assign p_old       = slevel_r[tgt];
  assign np          = join_member_r ? lvl_clamped : '0;
  assign lnext       = lcnt_r + CNT_W'(1);
  assign last_slot   = (idx_r == CNT_W'(NUM_SLOTS - 1));
  // The level walks stop below the requester level and below NUM_LEVELS.
  assign last_level  = (lnext >= {1'b0, lvl_r}) || (lnext >= CNT_W'(NUM_LEVELS));
  assign mark_ok     = !scanned_r[sidx] && !locked_r[sidx] && !running_r[sidx];
  assign mem_vec     = members_r[lidx];
  assign unl_vec     = mem_vec & ~locked_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    lcnt_nxt        = lcnt_r;
    sel_found_nxt   = sel_found_r;
    free_found_nxt  = free_found_r;
    ident_nxt       = ident_r;
    slevel_nxt      = slevel_r;
    scanned_nxt     = scanned_r;
    locked_nxt      = locked_r;
    running_nxt     = running_r;
    members_nxt     = members_r;
    counts_nxt      = counts_r;
    active_nxt      = active_r;
    cslot_nxt       = cslot_r;
    lvl_nxt         = lvl_r;
    id_nxt          = id_r;
    lock_in_nxt     = lock_in_r;
    run_in_nxt      = run_in_r;
    scan_in_nxt     = scan_in_r;
    join_member_nxt = join_member_r;
    sel_nxt         = sel_r;
    free_idx_nxt    = free_idx_r;
    found_nxt       = found_r;
    chosen_nxt      = chosen_r;
    tally_nxt       = tally_r;
    under_nxt       = under_r;
    wake_nxt        = wake_r;
    ureq.op         = UOP_CMP;
    ureq.a          = '0;
    ureq.b          = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cslot_nxt       = in_slot;
          lvl_nxt         = in_level;
          id_nxt          = in_stream_id;
          lock_in_nxt     = in_locked_flag;
          run_in_nxt      = in_running_flag;
          scan_in_nxt     = in_scanned_flag;
          join_member_nxt = (cmd_t'(in_command) == CMD_SET_PRI);
          idx_nxt         = '0;
          lcnt_nxt        = '0;
          sel_found_nxt   = 1'b0;
          free_found_nxt  = 1'b0;
          found_nxt       = 1'b0;
          chosen_nxt      = '0;
          tally_nxt       = '0;
          under_nxt       = 1'b0;
          wake_nxt        = 1'b0;
          case (cmd_t'(in_command))
            CMD_ALLOC:       state_nxt = S_ALLOC_SLOTS;
            CMD_SET_PRI:     state_nxt = slot_ok ? S_LEAVE : S_REPLY;
            CMD_REMOVE:      state_nxt = slot_ok ? S_LEAVE : S_REPLY;
            CMD_FREE:        state_nxt = slot_ok ? S_FREE : S_REPLY;
            CMD_STATUS:      state_nxt = slot_ok ? S_STATUS : S_REPLY;
            CMD_CLEAR:       state_nxt = S_CLEAR;
            CMD_COUNT_BELOW: state_nxt = (in_level != '0) ? S_COUNT_BELOW : S_REPLY;
            CMD_FIND:        state_nxt = (in_stream_id != '0) ? S_FIND : S_REPLY;
            CMD_COUNT_RUN:   state_nxt = S_COUNT_RUN;
            default:         state_nxt = S_REPLY;
          endcase
        end
      end

      S_ALLOC_SLOTS: begin
        // A free id wins at once; otherwise remember the first idle, unlocked slot.
        ureq.op = UOP_CMP;
        ureq.a  = ident_r[sidx];
        ureq.b  = '0;
        if (ursp.flag) begin
          sel_nxt       = sidx;
          sel_found_nxt = 1'b1;
          state_nxt     = S_ALLOC_FINISH;
        end else begin
          if (mark_ok && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = sidx;
          end
          if (last_slot) begin
            if (free_found_r || mark_ok) begin
              sel_nxt       = free_found_r ? free_idx_r : sidx;
              sel_found_nxt = 1'b1;
              state_nxt     = S_ALLOC_FINISH;
            end else if (lvl_r != '0) begin
              lcnt_nxt  = '0;
              state_nxt = S_ALLOC_LEVELS;
            end else begin
              state_nxt = S_REPLY;
            end
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end

      S_ALLOC_LEVELS: begin
        // One level list per cycle: an unlocked member ends the walk, otherwise
        // the last member seen so far stands as the fallback choice.
        if (unl_vec != '0) begin
          sel_nxt       = first_set(unl_vec);
          sel_found_nxt = 1'b1;
          state_nxt     = S_ALLOC_FINISH;
        end else begin
          if (mem_vec != '0) begin
            sel_nxt       = last_set(mem_vec);
            sel_found_nxt = 1'b1;
          end
          if (last_level) begin
            state_nxt = (sel_found_r || (mem_vec != '0)) ? S_ALLOC_FINISH : S_REPLY;
          end else begin
            lcnt_nxt = lnext;
          end
        end
      end

      S_ALLOC_FINISH: begin
        ureq.op    = UOP_INC;
        ureq.a     = ID_W'(active_r);
        active_nxt = ursp.res[CTR_W-1:0];
        wake_nxt   = ursp.flag;
        found_nxt  = 1'b1;
        chosen_nxt = 2'(sel_r);
        state_nxt  = S_REPLY;
      end

      S_LEAVE: begin
        members_nxt[p_old][tgt] = 1'b0;
        ureq.op                 = UOP_DEC;
        ureq.a                  = ID_W'(counts_r[p_old]);
        counts_nxt[p_old]       = ursp.res[CTR_W-1:0];
        under_nxt               = ursp.flag;
        state_nxt               = S_JOIN;
      end

      S_JOIN: begin
        // Set priority joins the new level; remove only credits level 0.
        ureq.op        = UOP_INC;
        ureq.a         = ID_W'(counts_r[np]);
        counts_nxt[np] = ursp.res[CTR_W-1:0];
        if (join_member_r) begin
          members_nxt[np][tgt] = 1'b1;
          slevel_nxt[tgt]      = np;
        end
        state_nxt = S_REPLY;
      end

      S_FREE: begin
        ident_nxt[tgt]   = '0;
        slevel_nxt[tgt]  = '0;
        scanned_nxt[tgt] = 1'b0;
        locked_nxt[tgt]  = 1'b0;
        running_nxt[tgt] = 1'b0;
        ureq.op          = UOP_DEC;
        ureq.a           = ID_W'(active_r);
        active_nxt       = ursp.res[CTR_W-1:0];
        state_nxt        = S_REPLY;
      end

      S_STATUS: begin
        ident_nxt[tgt]   = id_r;
        locked_nxt[tgt]  = lock_in_r;
        running_nxt[tgt] = run_in_r;
        scanned_nxt[tgt] = scan_in_r;
        state_nxt        = S_REPLY;
      end

      S_CLEAR: begin
        scanned_nxt = '0;
        state_nxt   = S_REPLY;
      end

      S_COUNT_BELOW: begin
        ureq.op   = UOP_ADD;
        ureq.a    = ID_W'(tally_r);
        ureq.b    = ID_W'(counts_r[lidx]);
        tally_nxt = ursp.res;
        if (last_level) begin
          state_nxt = S_REPLY;
        end else begin
          lcnt_nxt = lnext;
        end
      end

      S_FIND: begin
        ureq.op = UOP_CMP;
        ureq.a  = ident_r[sidx];
        ureq.b  = id_r;
        if (ursp.flag) begin
          found_nxt  = 1'b1;
          chosen_nxt = 2'(sidx);
          state_nxt  = S_REPLY;
        end else if (last_slot) begin
          state_nxt = S_REPLY;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_COUNT_RUN: begin
        ureq.op   = UOP_ADD;
        ureq.a    = ID_W'(tally_r);
        ureq.b    = ID_W'(running_r[sidx]);
        tally_nxt = ursp.res;
        if (last_slot) begin
          state_nxt = S_REPLY;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_REPLY: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      lcnt_r       <= '0;
      sel_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ident_r[i]  <= '0;
        slevel_r[i] <= '0;
      end
      scanned_r <= '0;
      locked_r  <= '0;
      running_r <= '0;
      for (int p = 0; p < NUM_LEVELS; p++) begin
        members_r[p] <= '0;
        counts_r[p]  <= (p == 0) ? CTR_W'(NUM_SLOTS) : '0;
      end
      active_r <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      lcnt_r       <= lcnt_nxt;
      sel_found_r  <= sel_found_nxt;
      free_found_r <= free_found_nxt;
      ident_r      <= ident_nxt;
      slevel_r     <= slevel_nxt;
      scanned_r    <= scanned_nxt;
      locked_r     <= locked_nxt;
      running_r    <= running_nxt;
      members_r    <= members_nxt;
      counts_r     <= counts_nxt;
      active_r     <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cslot_r       <= cslot_nxt;
    lvl_r         <= lvl_nxt;
    id_r          <= id_nxt;
    lock_in_r     <= lock_in_nxt;
    run_in_r      <= run_in_nxt;
    scan_in_r     <= scan_in_nxt;
    join_member_r <= join_member_nxt;
    sel_r         <= sel_nxt;
    free_idx_r    <= free_idx_nxt;
    found_r       <= found_nxt;
    chosen_r      <= chosen_nxt;
    tally_r       <= tally_nxt;
    under_r       <= under_nxt;
    wake_r        <= wake_nxt;
  end

  assign out_valid       = (state_r == S_REPLY);
  assign out_found       = found_r;
  assign out_chosen_slot = chosen_r;
  assign out_tally       = tally_r;
  assign out_underflow   = under_r;
  assign out_wake        = wake_r;

  // A result beat lasts exactly one cycle and the block is idle right after it.
  a_reply_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe held longer than one cycle");

  // A taken command always keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken without the block turning busy");

  // The finishing step of an allocate only runs with a chosen slot.
  a_finish_has_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC_FINISH) |-> sel_found_r)
    else $error("allocate finished without a chosen slot");

  // A wake is only reported together with a successful allocation.
  a_wake_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake) |-> out_found)
    else $error("wake reported without a found slot");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the stream slot priority allocator.
module tb
  import ssp_pkg::*;
();

  localparam int NUM_SLOTS    = 4;
  localparam int NUM_LEVELS   = 11;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_GAP      = 11;
  localparam int MAX_REPORTS  = 10;
  // The slowest command is allocate, which walks the slots and then the levels; leave margin.
  localparam int DRAIN_CYCLES = NUM_SLOTS + NUM_LEVELS + 8;
  // Highest value a 4-bit command or level port can carry; beyond the used codes and levels.
  localparam logic [3:0] CMD_CODE_TOP = 4'hF;
  localparam logic [3:0] LEVEL_TOP    = 4'hF;
  // Command mixes of the random part.
  localparam int MIX_GENERAL = 0;
  localparam int MIX_FILL    = 1;

  // One command beat, field by field.
  typedef struct packed {
    logic [3:0]      command;
    logic [1:0]      slot;
    logic [3:0]      level;
    logic [ID_W-1:0] stream_id;
    logic            locked_flag;
    logic            running_flag;
    logic            scanned_flag;
  } cmd_beat_t;

  // One result beat, in port order.
  typedef struct packed {
    logic               found;
    logic [1:0]         chosen_slot;
    logic [TALLY_W-1:0] tally;
    logic               underflow;
    logic               wake;
  } reply_t;

  // Shadow copy of the slot table, level lists and counters. Every accepted command
  // beat updates the copy and queues the reply it must produce; every result beat is
  // checked against the oldest queued reply.
  class slot_table_tracker;
    bit [ID_W-1:0]      ident    [NUM_SLOTS];
    bit [3:0]           level_of [NUM_SLOTS];
    bit                 scanned  [NUM_SLOTS];
    bit                 locked   [NUM_SLOTS];
    bit                 running  [NUM_SLOTS];
    bit [NUM_SLOTS-1:0] members  [NUM_LEVELS];
    bit [CTR_W-1:0]     counts   [NUM_LEVELS];
    bit [CTR_W-1:0]     active;
    reply_t             expected_replies[$];
    int unsigned        mismatches;

    function new();
      // Everything starts at zero except the level 0 counter, which holds every slot.
      counts[0]  = CTR_W'(NUM_SLOTS);
      mismatches = 0;
    endfunction

    // Takes a slot off its level's list; returns 1 when that counter was already zero.
    function bit drop_from_level(int s);
      int p;
      p = (level_of[s] < NUM_LEVELS) ? int'(level_of[s]) : NUM_LEVELS - 1;
      members[p][s] = 1'b0;
      if (counts[p] == 0) return 1'b1;
      counts[p]--;
      return 1'b0;
    endfunction

    function void note_command(cmd_beat_t b);
      reply_t r;
      int     sel, bound, s, np, i, p, sum;
      bit     done;
      r   = '0;
      sel = -1;
      s   = b.slot;
      case (b.command)
        CMD_ALLOC: begin
          // First an empty slot, then an idle one, then a member of a lower level.
          for (i = 0; i < NUM_SLOTS; i++)
            if (sel < 0 && ident[i] == 0) sel = i;
          for (i = 0; i < NUM_SLOTS; i++)
            if (sel < 0 && !scanned[i] && !locked[i] && !running[i]) sel = i;
          if (sel < 0 && b.level != 0) begin
            bound = (b.level < NUM_LEVELS) ? int'(b.level) : NUM_LEVELS;
            done  = 1'b0;
            for (p = 0; p < bound; p++)
              for (i = 0; i < NUM_SLOTS; i++)
                if (!done && members[p][i]) begin
                  sel = i;
                  if (!locked[i]) done = 1'b1;
                end
          end
          if (sel >= 0) begin
            r.found       = 1'b1;
            r.chosen_slot = 2'(sel);
            if (active != '1) begin
              active++;
              r.wake = (active == 1);
            end
          end
        end
        CMD_SET_PRI: begin
          np = (b.level < NUM_LEVELS) ? int'(b.level) : NUM_LEVELS - 1;
          r.underflow    = drop_from_level(s);
          members[np][s] = 1'b1;
          if (counts[np] != '1) counts[np]++;
          level_of[s] = 4'(np);
        end
        CMD_REMOVE: begin
          r.underflow = drop_from_level(s);
          if (counts[0] != '1) counts[0]++;
        end
        CMD_FREE: begin
          // Lists and counters keep their contents.
          ident[s]    = '0;
          level_of[s] = '0;
          scanned[s]  = 1'b0;
          locked[s]   = 1'b0;
          running[s]  = 1'b0;
          if (active != 0) active--;
        end
        CMD_STATUS: begin
          ident[s]   = b.stream_id;
          locked[s]  = b.locked_flag;
          running[s] = b.running_flag;
          scanned[s] = b.scanned_flag;
        end
        CMD_CLEAR: begin
          foreach (scanned[k]) scanned[k] = 1'b0;
        end
        CMD_COUNT_BELOW: begin
          bound = (b.level < NUM_LEVELS) ? int'(b.level) : NUM_LEVELS;
          sum   = 0;
          for (p = 0; p < bound; p++) sum += counts[p];
          r.tally = TALLY_W'(sum);
        end
        CMD_FIND: begin
          // An id of zero marks a free slot and never matches.
          if (b.stream_id != 0)
            for (i = 0; i < NUM_SLOTS; i++)
              if (!r.found && ident[i] == b.stream_id) begin
                r.found       = 1'b1;
                r.chosen_slot = 2'(i);
              end
        end
        CMD_COUNT_RUN: begin
          sum = 0;
          foreach (running[k]) sum += running[k];
          r.tally = TALLY_W'(sum);
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void match_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"result beat with none expected: ",
                    "found=%0d slot=%0d tally=%0d uf=%0d wake=%0d"},
                   got.found, got.chosen_slot, got.tally, got.underflow, got.wake);
        return;
      end
      want = expected_replies.pop_front();
      if (got.found !== want.found || got.chosen_slot !== want.chosen_slot ||
          got.tally !== want.tally || got.underflow !== want.underflow ||
          got.wake !== want.wake) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"result mismatch: expected ",
                    "found=%0d slot=%0d tally=%0d uf=%0d wake=%0d, %s"},
                   want.found, want.chosen_slot, want.tally, want.underflow, want.wake,
                   $sformatf("got found=%0d slot=%0d tally=%0d uf=%0d wake=%0d",
                             got.found, got.chosen_slot, got.tally, got.underflow, got.wake));
      end
    endfunction
  endclass

  // Every input holds a known value from time zero; reset is low until released.
  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic [3:0]        in_command      = '0;
  logic [1:0]        in_slot         = '0;
  logic [3:0]        in_level        = '0;
  logic [ID_W-1:0]   in_stream_id    = '0;
  logic              in_locked_flag  = 1'b0;
  logic              in_running_flag = 1'b0;
  logic              in_scanned_flag = 1'b0;
  logic              busy;
  logic              out_valid;
  logic              out_found;
  logic [1:0]        out_chosen_slot;
  logic [TALLY_W-1:0] out_tally;
  logic              out_underflow;
  logic              out_wake;
  reply_t            seen_reply;

  slot_table_tracker book;
  // Number of coming beats that follow their predecessor with no idle cycles.
  int unsigned       burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_slot_priority_allocator #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_LEVELS(NUM_LEVELS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_slot        (in_slot),
    .in_level       (in_level),
    .in_stream_id   (in_stream_id),
    .in_locked_flag (in_locked_flag),
    .in_running_flag(in_running_flag),
    .in_scanned_flag(in_scanned_flag),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_chosen_slot(out_chosen_slot),
    .out_tally      (out_tally),
    .out_underflow  (out_underflow),
    .out_wake       (out_wake)
  );

  assign seen_reply = {out_found, out_chosen_slot, out_tally, out_underflow, out_wake};

  // The receiver cannot stall, so every result beat is taken at the edge that ends
  // its cycle. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) book.match_reply(seen_reply);
  end

  // Drives one command beat. The sender first idles for a random number of cycles
  // (none inside a burst), then holds start and the fields until an edge finds busy
  // low; that edge takes the beat, and the shadow table is updated there.
  task automatic send_beat(input cmd_beat_t b);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_command      <= b.command;
    in_slot         <= b.slot;
    in_level        <= b.level;
    in_stream_id    <= b.stream_id;
    in_locked_flag  <= b.locked_flag;
    in_running_flag <= b.running_flag;
    in_scanned_flag <= b.scanned_flag;
    do @(posedge clk); while (busy !== 1'b0);
    book.note_command(b);
  endtask

  task automatic send(input logic [3:0] command, input logic [1:0] slot,
                      input logic [3:0] level, input logic [ID_W-1:0] stream_id,
                      input logic lk, input logic rn, input logic sc);
    send_beat('{command, slot, level, stream_id, lk, rn, sc});
  endtask

  // Random beats. The general mix covers every command, including the unused codes.
  // The fill mix leaves out free, so allocations pile up until the active stream
  // count saturates, and removes keep raising the level 0 counter toward its cap.
  // Ids come mostly from a small pool so that find id and empty-slot checks hit often.
  task automatic run_random(input int mix, input int beats);
    cmd_beat_t   b;
    int unsigned r;
    repeat (beats) begin
      r = $urandom_range(0, 99);
      if (mix == MIX_FILL) begin
        if      (r < 50) b.command = CMD_ALLOC;
        else if (r < 80) b.command = CMD_REMOVE;
        else if (r < 85) b.command = CMD_SET_PRI;
        else if (r < 93) b.command = CMD_STATUS;
        else if (r < 96) b.command = CMD_COUNT_BELOW;
        else if (r < 98) b.command = CMD_FIND;
        else             b.command = CMD_COUNT_RUN;
      end else begin
        if      (r < 20) b.command = CMD_ALLOC;
        else if (r < 32) b.command = CMD_SET_PRI;
        else if (r < 42) b.command = CMD_REMOVE;
        else if (r < 52) b.command = CMD_FREE;
        else if (r < 72) b.command = CMD_STATUS;
        else if (r < 76) b.command = CMD_CLEAR;
        else if (r < 82) b.command = CMD_COUNT_BELOW;
        else if (r < 90) b.command = CMD_FIND;
        else if (r < 95) b.command = CMD_COUNT_RUN;
        else             b.command = 4'($urandom_range(CMD_COUNT_RUN + 1, CMD_CODE_TOP));
      end
      b.slot = 2'($urandom_range(0, NUM_SLOTS - 1));
      // Now and then a level past the top one, which must be clamped or bounded.
      if ($urandom_range(0, 99) < 85) b.level = 4'($urandom_range(0, NUM_LEVELS - 1));
      else                            b.level = 4'($urandom_range(NUM_LEVELS, LEVEL_TOP));
      r = $urandom_range(0, 99);
      if (b.command == CMD_FIND && r < 50)
        b.stream_id = book.ident[2'($urandom_range(0, NUM_SLOTS - 1))];
      else if (r < 20) b.stream_id = '0;
      else if (r < 70) b.stream_id = $urandom_range(1, 6);
      else if (r < 75) b.stream_id = '1;
      else             b.stream_id = $urandom;
      b.locked_flag  = 1'($urandom_range(0, 1));
      b.running_flag = 1'($urandom_range(0, 1));
      b.scanned_flag = 1'($urandom_range(0, 1));
      send_beat(b);
    end
  endtask

  initial begin
    book = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Empty table: counts, a find with id zero, and an allocate that
    // takes the first empty slot and wakes the block.
    send(CMD_COUNT_BELOW, 0, LEVEL_TOP, '0, 0, 0, 0);
    send(CMD_COUNT_RUN,   0, 0, '0, 0, 0, 0);
    send(CMD_FIND,        0, 0, '0, 0, 0, 0);
    send(CMD_ALLOC,       0, 0, '0, 0, 0, 0);
    // Fill every slot with extreme ids and a varied mix of marks.
    send(CMD_STATUS, 0, 0, 32'hFFFF_FFFF, 1, 1, 1);
    send(CMD_STATUS, 1, 0, 32'h0000_0001, 0, 0, 0);
    send(CMD_STATUS, 2, 0, 32'h8000_0000, 0, 1, 0);
    send(CMD_STATUS, 3, 0, 32'h5A5A_A5A5, 1, 0, 1);
    // No empty slot: slot 1 is the only idle one.
    send(CMD_ALLOC, 0, 0, '0, 0, 0, 0);
    send(CMD_FIND,  0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    // A new priority past the top level is clamped to the top level.
    send(CMD_SET_PRI, 1, LEVEL_TOP, '0, 0, 0, 0);
    send(CMD_STATUS,  1, 0, 32'h0000_0007, 0, 0, 1);
    // Nothing idle and a requester at level zero: allocate finds nothing.
    send(CMD_ALLOC,   0, 0, '0, 0, 0, 0);
    send(CMD_SET_PRI, 0, 3, '0, 0, 0, 0);
    send(CMD_SET_PRI, 2, 5, '0, 0, 0, 0);
    // Lower-level scan: an unlocked member wins; with only locked ones the last seen.
    send(CMD_ALLOC, 0, LEVEL_TOP, '0, 0, 0, 0);
    send(CMD_ALLOC, 0, 4, '0, 0, 0, 0);
    // The second remove of the same slot finds its counter already empty.
    send(CMD_REMOVE, 1, 0, '0, 0, 0, 0);
    send(CMD_REMOVE, 1, 0, '0, 0, 0, 0);
    send(CMD_COUNT_BELOW, 0, 4'(NUM_LEVELS), '0, 0, 0, 0);
    send(CMD_FREE,  0, 0, '0, 0, 0, 0);
    send(CMD_FREE,  3, 0, '0, 0, 0, 0);
    send(CMD_CLEAR, 0, 0, '0, 0, 0, 0);
    send(CMD_COUNT_RUN, 0, 0, '0, 0, 0, 0);
    // Unused command codes give an all-zero result.
    send(4'(CMD_COUNT_RUN + 1), 0, 0, '0, 0, 0, 0);
    send(CMD_CODE_TOP, 3, LEVEL_TOP, '1, 1, 1, 1);

    run_random(MIX_GENERAL, 400);
    run_random(MIX_FILL, 650);
    run_random(MIX_GENERAL, 250);
    start <= 1'b0;

    // Let every outstanding result arrive, then watch a little longer for strays.
    while (book.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Several times the slowest correct run: every beat with the longest idle gap and
  // the longest allocate scan.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ stream_slot_priority_allocator.f @@
rtl/core/ssp_pkg.sv
rtl/core/ssp_unit.sv
rtl/core/stream_slot_priority_allocator.sv
sim/tb.sv
